// ----- rtl/mbrm_pkg.sv -----
package mbrm_pkg;

	// Input opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_RX    = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_SLAVE_ID     = 3'd0;
	localparam logic [2:0] CFG_TIMEOUT      = 3'd1;
	localparam logic [2:0] CFG_FRAME_GAP    = 3'd2;
	localparam logic [2:0] CFG_TEMP_REG     = 3'd3;
	localparam logic [2:0] CFG_HUMIDITY_REG = 3'd4;

	// Configuration reset values
	localparam logic [7:0]  SLAVE_ID_RST     = 8'd1;
	localparam logic [9:0]  TIMEOUT_RST      = 10'd500;
	localparam logic [5:0]  FRAME_GAP_RST    = 6'd5;
	localparam logic [15:0] TEMP_REG_RST     = 16'd1;
	localparam logic [15:0] HUMIDITY_REG_RST = 16'd2;

	// Frame constants
	localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
	localparam logic [7:0]  REPLY_BYTES     = 8'h02;
	localparam logic [7:0]  QTY_HI          = 8'h00;
	localparam logic [7:0]  QTY_LO          = 8'h01;
	localparam logic [2:0]  REPLY_LEN       = 3'd7;
	localparam logic [2:0]  CRC_SPAN        = 3'd5;
	localparam logic [2:0]  REQ_CRC_SPAN    = 3'd6;
	localparam logic [2:0]  REQ_LAST_IDX    = 3'd7;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [9:0]  ELAPSED_MAX     = 10'd1023;
	localparam logic [5:0]  QUIET_MAX       = 6'd63;

	// Range limits in tenths
	localparam logic signed [15:0] TEMP_MIN = -16'sd400;
	localparam logic signed [15:0] TEMP_MAX = 16'sd1250;
	localparam logic [15:0]        HUM_MAX  = 16'd1000;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_LONG   = 3'd2,
		ST_HEADER = 3'd3,
		ST_CRC    = 3'd4,
		ST_RANGE  = 3'd5
	} status_t;

	// One unit of work handed from the front to the back.
	typedef struct packed {
		logic               is_report;
		logic [7:0]         slave;
		logic [15:0]        addr;
		status_t            status;
		logic signed [16:0] reading;
	} job_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/mbrm_ifs.sv -----
interface mbrm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] register_address;
	logic [7:0]  rx_byte;

	modport source(output valid, output opcode, output register_address, output rx_byte,
		input ready);
	modport sink(input valid, input opcode, input register_address, input rx_byte,
		output ready);
endinterface

interface mbrm_result_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [7:0]         tx_byte;
	logic               drive_enable;
	logic               last;
	logic signed [16:0] reading_tenths;
	logic [2:0]         status;

	modport source(output valid, output result_kind, output tx_byte, output drive_enable,
		output last, output reading_tenths, output status, input ready);
	modport sink(input valid, input result_kind, input tx_byte, input drive_enable,
		input last, input reading_tenths, input status, output ready);
endinterface

interface mbrm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/mbrm_front.sv -----
module mbrm_front (
	input  logic              clk,
	input  logic              arst_n,
	mbrm_item_if.sink         items,
	mbrm_cfg_if.sink          cfg,
	input  logic              q_full,
	output logic              q_push,
	output mbrm_pkg::job_t    q_job
);

	logic [7:0]  slave_id_q;
	logic [9:0]  timeout_q;
	logic [5:0]  gap_q;
	logic [15:0] temp_reg_q;
	logic [15:0] hum_reg_q;

	logic        phase_q;
	logic [15:0] req_reg_q;
	logic [7:0]  bytes_q [mbrm_pkg::REPLY_LEN];
	logic [2:0]  count_q;
	logic        overflow_q;
	logic [15:0] crc_q;
	logic [9:0]  elapsed_q;
	logic [5:0]  quiet_q;

	logic        accept;
	logic        is_start;
	logic        is_rx;
	logic        is_tick;
	logic [9:0]  elapsed_n;
	logic [5:0]  quiet_n;
	logic        done;
	logic [15:0] raw;
	mbrm_pkg::status_t  rpt_status;
	logic signed [16:0] rpt_reading;

	assign items.ready = !q_full;
	assign cfg.ready   = 1'b1;
	assign accept      = items.valid && items.ready;
	assign is_start    = accept && (items.opcode == mbrm_pkg::OP_START);
	assign is_rx       = accept && phase_q && (items.opcode == mbrm_pkg::OP_RX);
	assign is_tick     = accept && phase_q && (items.opcode == mbrm_pkg::OP_TICK);

	assign elapsed_n = (elapsed_q == mbrm_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 10'd1;
	assign quiet_n   = (quiet_q == mbrm_pkg::QUIET_MAX) ? quiet_q : quiet_q + 6'd1;
	assign done      = ((count_q == mbrm_pkg::REPLY_LEN) && (quiet_n >= gap_q)) ||
		(elapsed_n >= timeout_q);

	assign raw = {bytes_q[3], bytes_q[4]};

	// Reply check in priority order: overflow, length, header, CRC, range.
	always_comb begin
		rpt_status  = mbrm_pkg::ST_OK;
		rpt_reading = '0;
		if (overflow_q) begin
			rpt_status = mbrm_pkg::ST_LONG;
		end else if (count_q != mbrm_pkg::REPLY_LEN) begin
			rpt_status = mbrm_pkg::ST_SHORT;
		end else if (bytes_q[0] != slave_id_q || bytes_q[1] != mbrm_pkg::FUNC_READ_INPUT ||
			bytes_q[2] != mbrm_pkg::REPLY_BYTES) begin
			rpt_status = mbrm_pkg::ST_HEADER;
		end else if (bytes_q[5] != crc_q[7:0] || bytes_q[6] != crc_q[15:8]) begin
			rpt_status = mbrm_pkg::ST_CRC;
		end else if (req_reg_q == temp_reg_q) begin
			if ($signed(raw) >= mbrm_pkg::TEMP_MIN && $signed(raw) <= mbrm_pkg::TEMP_MAX) begin
				rpt_reading = {raw[15], raw};
			end else begin
				rpt_status = mbrm_pkg::ST_RANGE;
			end
		end else if (req_reg_q == hum_reg_q && raw > mbrm_pkg::HUM_MAX) begin
			rpt_status = mbrm_pkg::ST_RANGE;
		end else begin
			rpt_reading = {1'b0, raw};
		end
	end

	assign q_push = is_start || (is_tick && done);

	always_comb begin
		q_job           = '0;
		q_job.is_report = !is_start;
		q_job.slave     = slave_id_q;
		q_job.addr      = items.register_address;
		q_job.status    = rpt_status;
		q_job.reading   = rpt_reading;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_id_q <= mbrm_pkg::SLAVE_ID_RST;
			timeout_q  <= mbrm_pkg::TIMEOUT_RST;
			gap_q      <= mbrm_pkg::FRAME_GAP_RST;
			temp_reg_q <= mbrm_pkg::TEMP_REG_RST;
			hum_reg_q  <= mbrm_pkg::HUMIDITY_REG_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				mbrm_pkg::CFG_SLAVE_ID:     slave_id_q <= cfg.data[7:0];
				mbrm_pkg::CFG_TIMEOUT:      timeout_q  <= cfg.data[9:0];
				mbrm_pkg::CFG_FRAME_GAP:    gap_q      <= cfg.data[5:0];
				mbrm_pkg::CFG_TEMP_REG:     temp_reg_q <= cfg.data;
				mbrm_pkg::CFG_HUMIDITY_REG: hum_reg_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			req_reg_q  <= '0;
			count_q    <= '0;
			overflow_q <= 1'b0;
			crc_q      <= mbrm_pkg::CRC_INIT;
			elapsed_q  <= '0;
			quiet_q    <= '0;
		end else if (is_start) begin
			phase_q    <= 1'b1;
			req_reg_q  <= items.register_address;
			count_q    <= '0;
			overflow_q <= 1'b0;
			crc_q      <= mbrm_pkg::CRC_INIT;
			elapsed_q  <= '0;
			quiet_q    <= '0;
		end else if (is_rx) begin
			quiet_q <= '0;
			if (count_q < mbrm_pkg::REPLY_LEN) begin
				if (count_q < mbrm_pkg::CRC_SPAN) begin
					crc_q <= mbrm_pkg::crc_byte(crc_q, items.rx_byte);
				end
				count_q <= count_q + 3'd1;
			end else begin
				overflow_q <= 1'b1;
			end
		end else if (is_tick) begin
			elapsed_q <= elapsed_n;
			quiet_q   <= quiet_n;
			if (done) begin
				phase_q <= 1'b0;
			end
		end
	end

	// Reply bytes need no reset; an entry is read only once the count has passed it.
	always_ff @(posedge clk) begin
		if (is_rx && count_q < mbrm_pkg::REPLY_LEN) begin
			bytes_q[count_q] <= items.rx_byte;
		end
	end

endmodule

// ----- rtl/mbrm_queue.sv -----
module mbrm_queue #(
	parameter int DEPTH = mbrm_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbrm_pkg::job_t push_job,
	input  logic           pop,
	output mbrm_pkg::job_t head,
	output logic           full,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mbrm_pkg::job_t entries_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- rtl/mbrm_back.sv -----
module mbrm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mbrm_pkg::job_t q_head,
	input  logic           q_empty,
	output logic           q_pop,
	mbrm_result_if.source  results
);

	logic               out_valid_q;
	logic               kind_q;
	logic [7:0]         tx_q;
	logic               de_q;
	logic               last_q;
	logic signed [16:0] reading_q;
	logic [2:0]         status_q;

	logic               active_q;
	logic [2:0]         idx_q;
	logic [7:0]         slave_q;
	logic [15:0]        addr_q;
	logic [15:0]        crc_q;

	logic               load;
	logic [7:0]         req_byte;

	assign results.valid          = out_valid_q;
	assign results.result_kind    = kind_q;
	assign results.tx_byte        = tx_q;
	assign results.drive_enable   = de_q;
	assign results.last           = last_q;
	assign results.reading_tenths = reading_q;
	assign results.status         = status_q;

	// The output register may be refilled when empty or being taken this cycle.
	assign load  = !out_valid_q || results.ready;
	assign q_pop = load && !active_q && !q_empty;

	always_comb begin
		case (idx_q)
			3'd0:    req_byte = slave_q;
			3'd1:    req_byte = mbrm_pkg::FUNC_READ_INPUT;
			3'd2:    req_byte = addr_q[15:8];
			3'd3:    req_byte = addr_q[7:0];
			3'd4:    req_byte = mbrm_pkg::QTY_HI;
			3'd5:    req_byte = mbrm_pkg::QTY_LO;
			3'd6:    req_byte = crc_q[7:0];
			default: req_byte = crc_q[15:8];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			if (active_q) begin
				out_valid_q <= 1'b1;
				idx_q       <= idx_q + 3'd1;
				if (idx_q == mbrm_pkg::REQ_LAST_IDX) begin
					active_q <= 1'b0;
				end
			end else if (!q_empty) begin
				out_valid_q <= q_head.is_report;
				if (!q_head.is_report) begin
					active_q <= 1'b1;
					idx_q    <= '0;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (active_q) begin
				kind_q    <= 1'b0;
				tx_q      <= req_byte;
				de_q      <= 1'b1;
				last_q    <= (idx_q == mbrm_pkg::REQ_LAST_IDX);
				reading_q <= '0;
				status_q  <= 3'(mbrm_pkg::ST_OK);
				if (idx_q < mbrm_pkg::REQ_CRC_SPAN) begin
					crc_q <= mbrm_pkg::crc_byte(crc_q, req_byte);
				end
			end else if (!q_empty) begin
				if (q_head.is_report) begin
					kind_q    <= 1'b1;
					tx_q      <= '0;
					de_q      <= 1'b0;
					last_q    <= 1'b0;
					reading_q <= q_head.reading;
					status_q  <= 3'(q_head.status);
				end else begin
					slave_q <= q_head.slave;
					addr_q  <= q_head.addr;
					crc_q   <= mbrm_pkg::CRC_INIT;
				end
			end
		end
	end

endmodule

// ----- rtl/modbus_rtu_register_read_master_unit.sv -----
// Channel   Role    Payload
// items     sink    opcode, register_address, rx_byte
// results   source  result_kind, tx_byte, drive_enable, last, reading_tenths, status
// cfg       sink    index, data (always ready)
//
// The front takes one item per cycle while the job queue has room; bytes and ticks
// update the receive state in that cycle.
// A start becomes eight request bytes and a report one result; the back end first
// loads the job, then one byte per cycle while results is ready; CRC is byte-wide.
// A stall on results fills the job queue, and then items stalls.
// Reset clears all control state at once; there is no clearing pass.
module modbus_rtu_register_read_master_unit #(
	parameter int QUEUE_DEPTH = mbrm_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	mbrm_item_if.sink     items,
	mbrm_result_if.source results,
	mbrm_cfg_if.sink      cfg
);

	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	mbrm_pkg::job_t push_job;
	mbrm_pkg::job_t head_job;

	mbrm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job)
	);

	mbrm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	mbrm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (head_job),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.results (results)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("job popped from an empty queue");

	a_report_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.result_kind) |->
		(results.tx_byte == 8'd0 && !results.drive_enable && !results.last))
		else $error("report carries request byte fields");

	a_reading_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.reading_tenths != 17'sd0) |->
		(results.result_kind && results.status == 3'(mbrm_pkg::ST_OK)))
		else $error("reading given with a failed status or on a request byte");
`endif

endmodule
